### rtl/hbit_pkg.sv
// shared types and defaults for the hitbox intersection test
`default_nettype none

package hbit_pkg;

  localparam int unsigned HBIT_COORD_BITS = 16;

  typedef enum logic [1:0] {
    MODE_MISS = 2'd0,
    MODE_RECT = 2'd1,
    MODE_DIST = 2'd2
  } hbit_mode_e;

  typedef struct packed {
    hbit_mode_e mode;
    logic       rr_hit;
  } hbit_flags_t;

endpackage

`default_nettype wire

### rtl/hbit_box_if.sv
// input channel carrying one pair of hitboxes per beat
`default_nettype none

interface hbit_box_if #(
  parameter int unsigned COORD_BITS = hbit_pkg::HBIT_COORD_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic                         first_kind;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic [COORD_BITS-1:0]        first_size;
  logic [COORD_BITS-1:0]        first_height;
  logic                         second_kind;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic [COORD_BITS-1:0]        second_size;
  logic [COORD_BITS-1:0]        second_height;
  logic                         same_box;

  modport source (
    output valid, first_kind, first_x, first_y, first_size, first_height,
    output second_kind, second_x, second_y, second_size, second_height, same_box,
    input  ready
  );

  modport sink (
    input  valid, first_kind, first_x, first_y, first_size, first_height,
    input  second_kind, second_x, second_y, second_size, second_height, same_box,
    output ready
  );
endinterface

`default_nettype wire

### rtl/hbit_hit_if.sv
// output channel carrying one hit bit per beat
`default_nettype none

interface hbit_hit_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );
endinterface

`default_nettype wire

### rtl/hbit_prep.sv
// stage one: role selection, far edges, mode flags and radius (sum of both sizes for two circles)
`default_nettype none

module hbit_prep #(
  parameter  int unsigned COORD_BITS = hbit_pkg::HBIT_COORD_BITS,
  localparam int unsigned ExtBits    = COORD_BITS + 2,
  localparam int unsigned RadBits    = COORD_BITS + 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  hbit_box_if.sink                        box_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      hbit_pkg::hbit_flags_t      flags_o,
  output      logic signed [ExtBits-1:0]  a_x_o,
  output      logic signed [ExtBits-1:0]  a_y_o,
  output      logic signed [ExtBits-1:0]  a_xe_o,
  output      logic signed [ExtBits-1:0]  a_ye_o,
  output      logic signed [ExtBits-1:0]  b_x_o,
  output      logic signed [ExtBits-1:0]  b_y_o,
  output      logic signed [ExtBits-1:0]  b_xe_o,
  output      logic signed [ExtBits-1:0]  b_ye_o,
  output      logic [RadBits-1:0]         r_o
);
  import hbit_pkg::*;

  logic                      valid_q;
  logic                      take;
  logic                      rect_first;
  logic                      both_circ;
  logic signed [ExtBits-1:0] x1, y1, w1, h1, x2, y2, w2, h2;
  logic signed [ExtBits-1:0] a_w, a_h, b_w, b_h;
  hbit_flags_t               flags_d, flags_q;
  logic signed [ExtBits-1:0] a_x_d, a_y_d, a_xe_d, a_ye_d, b_x_d, b_y_d, b_xe_d, b_ye_d;
  logic signed [ExtBits-1:0] a_x_q, a_y_q, a_xe_q, a_ye_q, b_x_q, b_y_q, b_xe_q, b_ye_q;
  logic [RadBits-1:0]        r_d, r_q;

  assign box_i.ready = !valid_q || out_ready_i;
  assign take        = box_i.valid && box_i.ready;

  assign x1 = {{2{box_i.first_x[COORD_BITS-1]}}, box_i.first_x};
  assign y1 = {{2{box_i.first_y[COORD_BITS-1]}}, box_i.first_y};
  assign w1 = {2'b00, box_i.first_size};
  assign h1 = {2'b00, box_i.first_height};
  assign x2 = {{2{box_i.second_x[COORD_BITS-1]}}, box_i.second_x};
  assign y2 = {{2{box_i.second_y[COORD_BITS-1]}}, box_i.second_y};
  assign w2 = {2'b00, box_i.second_size};
  assign h2 = {2'b00, box_i.second_height};

  // box a is the rectangle whenever there is one, box b the other box
  assign rect_first = !box_i.first_kind;
  assign both_circ  = box_i.first_kind && box_i.second_kind;

  assign a_x_d = rect_first ? x1 : x2;
  assign a_y_d = rect_first ? y1 : y2;
  assign a_w   = rect_first ? w1 : w2;
  assign a_h   = rect_first ? h1 : h2;
  assign b_x_d = rect_first ? x2 : x1;
  assign b_y_d = rect_first ? y2 : y1;
  assign b_w   = rect_first ? w2 : w1;
  assign b_h   = rect_first ? h2 : h1;

  // a circle centre stands as a zero-size interval
  assign a_xe_d = a_x_d + (both_circ ? ExtBits'(0) : a_w);
  assign a_ye_d = a_y_d + (both_circ ? ExtBits'(0) : a_h);
  assign b_xe_d = b_x_d + b_w;
  assign b_ye_d = b_y_d + b_h;

  assign r_d = both_circ ? ({1'b0, box_i.first_size} + {1'b0, box_i.second_size})
                         : {1'b0, (rect_first ? box_i.second_size : box_i.first_size)};

  always_comb begin
    flags_d.rr_hit = 1'b0;
    if (box_i.same_box) begin
      flags_d.mode = MODE_MISS;
    end else if (!box_i.first_kind && !box_i.second_kind) begin
      flags_d.mode = MODE_RECT;
    end else begin
      flags_d.mode = MODE_DIST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (box_i.ready) begin
      valid_q <= box_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      flags_q <= flags_d;
      a_x_q   <= a_x_d;
      a_y_q   <= a_y_d;
      a_xe_q  <= a_xe_d;
      a_ye_q  <= a_ye_d;
      b_x_q   <= b_x_d;
      b_y_q   <= b_y_d;
      b_xe_q  <= b_xe_d;
      b_ye_q  <= b_ye_d;
      r_q     <= r_d;
    end
  end

  assign out_valid_o = valid_q;
  assign flags_o     = flags_q;
  assign a_x_o       = a_x_q;
  assign a_y_o       = a_y_q;
  assign a_xe_o      = a_xe_q;
  assign a_ye_o      = a_ye_q;
  assign b_x_o       = b_x_q;
  assign b_y_o       = b_y_q;
  assign b_xe_o      = b_xe_q;
  assign b_ye_o      = b_ye_q;
  assign r_o         = r_q;

endmodule

`default_nettype wire

### rtl/hbit_span.sv
// stage two: rectangle overlap and clamped distance per axis
`default_nettype none

module hbit_span #(
  parameter  int unsigned COORD_BITS = hbit_pkg::HBIT_COORD_BITS,
  localparam int unsigned ExtBits    = COORD_BITS + 2,
  localparam int unsigned RadBits    = COORD_BITS + 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire hbit_pkg::hbit_flags_t      flags_i,
  input  wire logic signed [ExtBits-1:0]  a_x_i,
  input  wire logic signed [ExtBits-1:0]  a_y_i,
  input  wire logic signed [ExtBits-1:0]  a_xe_i,
  input  wire logic signed [ExtBits-1:0]  a_ye_i,
  input  wire logic signed [ExtBits-1:0]  b_x_i,
  input  wire logic signed [ExtBits-1:0]  b_y_i,
  input  wire logic signed [ExtBits-1:0]  b_xe_i,
  input  wire logic signed [ExtBits-1:0]  b_ye_i,
  input  wire logic [RadBits-1:0]         r_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      hbit_pkg::hbit_flags_t      flags_o,
  output      logic [COORD_BITS-1:0]      dx_o,
  output      logic [COORD_BITS-1:0]      dy_o,
  output      logic [RadBits-1:0]         r_o
);
  import hbit_pkg::*;

  logic                      valid_q;
  logic                      take;
  hbit_flags_t               flags_d, flags_q;
  logic [COORD_BITS-1:0]     dx_d, dy_d, dx_q, dy_q;
  logic [RadBits-1:0]        r_q;
  logic signed [ExtBits-1:0] lo_x, hi_x, lo_y, hi_y;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  assign lo_x = a_x_i - b_x_i;
  assign hi_x = b_x_i - a_xe_i;
  assign lo_y = a_y_i - b_y_i;
  assign hi_y = b_y_i - a_ye_i;

  // distance from the centre to the interval, zero inside it
  always_comb begin
    if (b_x_i < a_x_i) begin
      dx_d = lo_x[COORD_BITS-1:0];
    end else if (b_x_i > a_xe_i) begin
      dx_d = hi_x[COORD_BITS-1:0];
    end else begin
      dx_d = '0;
    end
    if (b_y_i < a_y_i) begin
      dy_d = lo_y[COORD_BITS-1:0];
    end else if (b_y_i > a_ye_i) begin
      dy_d = hi_y[COORD_BITS-1:0];
    end else begin
      dy_d = '0;
    end
  end

  // closed intervals, so touching edges overlap
  always_comb begin
    flags_d        = flags_i;
    flags_d.rr_hit = !((a_x_i > b_xe_i) || (a_xe_i < b_x_i) ||
                       (a_y_i > b_ye_i) || (a_ye_i < b_y_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      flags_q <= flags_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      r_q     <= r_i;
    end
  end

  assign out_valid_o = valid_q;
  assign flags_o     = flags_q;
  assign dx_o        = dx_q;
  assign dy_o        = dy_q;
  assign r_o         = r_q;

`ifndef ASSERT_OFF
  a_span_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(dx_q) && $stable(dy_q) && $stable(r_q))
    else $error("span stage lost or changed a stalled beat");
`endif

endmodule

`default_nettype wire

### rtl/hbit_square.sv
// stage three: squares of the axis distances and of the radius
`default_nettype none

module hbit_square #(
  parameter  int unsigned COORD_BITS = hbit_pkg::HBIT_COORD_BITS,
  localparam int unsigned RadBits    = COORD_BITS + 1,
  localparam int unsigned SqBits     = 2 * COORD_BITS,
  localparam int unsigned RsqBits    = 2 * RadBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire hbit_pkg::hbit_flags_t flags_i,
  input  wire logic [COORD_BITS-1:0] dx_i,
  input  wire logic [COORD_BITS-1:0] dy_i,
  input  wire logic [RadBits-1:0]    r_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      hbit_pkg::hbit_flags_t flags_o,
  output      logic [SqBits-1:0]     dx_sq_o,
  output      logic [SqBits-1:0]     dy_sq_o,
  output      logic [RsqBits-1:0]    r_sq_o
);
  import hbit_pkg::*;

  logic               valid_q;
  logic               take;
  hbit_flags_t        flags_q;
  logic [SqBits-1:0]  dx_sq_d, dy_sq_d, dx_sq_q, dy_sq_q;
  logic [RsqBits-1:0] r_sq_d, r_sq_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  assign dx_sq_d = SqBits'(dx_i) * SqBits'(dx_i);
  assign dy_sq_d = SqBits'(dy_i) * SqBits'(dy_i);
  assign r_sq_d  = RsqBits'(r_i) * RsqBits'(r_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      flags_q <= flags_i;
      dx_sq_q <= dx_sq_d;
      dy_sq_q <= dy_sq_d;
      r_sq_q  <= r_sq_d;
    end
  end

  assign out_valid_o = valid_q;
  assign flags_o     = flags_q;
  assign dx_sq_o     = dx_sq_q;
  assign dy_sq_o     = dy_sq_q;
  assign r_sq_o      = r_sq_q;

endmodule

`default_nettype wire

### rtl/hbit_compare.sv
// stage four: hit choice by mode, sum of squares against radius square, result register
`default_nettype none

module hbit_compare #(
  parameter  int unsigned COORD_BITS = hbit_pkg::HBIT_COORD_BITS,
  localparam int unsigned RadBits    = COORD_BITS + 1,
  localparam int unsigned SqBits     = 2 * COORD_BITS,
  localparam int unsigned RsqBits    = 2 * RadBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire hbit_pkg::hbit_flags_t flags_i,
  input  wire logic [SqBits-1:0]     dx_sq_i,
  input  wire logic [SqBits-1:0]     dy_sq_i,
  input  wire logic [RsqBits-1:0]    r_sq_i,
  hbit_hit_if.source                 hit_o
);
  import hbit_pkg::*;

  logic              valid_q;
  logic              take;
  logic              hit_d, hit_q;
  logic [SqBits:0]   dist_sq;
  logic              in_reach;

  assign in_ready_o = !valid_q || hit_o.ready;
  assign take       = in_valid_i && in_ready_o;

  assign dist_sq  = {1'b0, dx_sq_i} + {1'b0, dy_sq_i};
  assign in_reach = {1'b0, dist_sq} <= r_sq_i;

  always_comb begin
    unique case (flags_i.mode)
      MODE_RECT: hit_d = flags_i.rr_hit;
      MODE_DIST: hit_d = in_reach;
      MODE_MISS: hit_d = 1'b0;
      default:   hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o.valid = valid_q;
  assign hit_o.hit   = hit_q;

`ifndef ASSERT_OFF
  a_same_box_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (flags_i.mode == MODE_MISS) |=> valid_q && !hit_q)
    else $error("same-box beat produced a hit");
`endif

endmodule

`default_nettype wire

### rtl/hitbox_intersection_test_core.sv
// top level of the hitbox intersection test pipeline
// a result beat passes the prep, span, square and compare registers in that order
// throughput: one beat per cycle while the result is taken; four register stages, each with its own valid bit
// input ready drops only when all four stages hold a beat and the result is not taken
// reset clears the stage valid bits only; payload registers are not reset
`default_nettype none

module hitbox_intersection_test_core #(
  parameter int unsigned COORD_BITS = hbit_pkg::HBIT_COORD_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hbit_box_if.sink   box_i,
  hbit_hit_if.source hit_o
);
  import hbit_pkg::*;

  localparam int unsigned ExtBits = COORD_BITS + 2;
  localparam int unsigned RadBits = COORD_BITS + 1;
  localparam int unsigned SqBits  = 2 * COORD_BITS;
  localparam int unsigned RsqBits = 2 * RadBits;

  logic                      p_valid, p_ready;
  hbit_flags_t               p_flags;
  logic signed [ExtBits-1:0] p_a_x, p_a_y, p_a_xe, p_a_ye, p_b_x, p_b_y, p_b_xe, p_b_ye;
  logic [RadBits-1:0]        p_r;

  logic                      s_valid, s_ready;
  hbit_flags_t               s_flags;
  logic [COORD_BITS-1:0]     s_dx, s_dy;
  logic [RadBits-1:0]        s_r;

  logic                      q_valid, q_ready;
  hbit_flags_t               q_flags;
  logic [SqBits-1:0]         q_dx_sq, q_dy_sq;
  logic [RsqBits-1:0]        q_r_sq;

  hbit_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_i       (box_i),
    .out_valid_o (p_valid),
    .out_ready_i (p_ready),
    .flags_o     (p_flags),
    .a_x_o       (p_a_x),
    .a_y_o       (p_a_y),
    .a_xe_o      (p_a_xe),
    .a_ye_o      (p_a_ye),
    .b_x_o       (p_b_x),
    .b_y_o       (p_b_y),
    .b_xe_o      (p_b_xe),
    .b_ye_o      (p_b_ye),
    .r_o         (p_r)
  );

  hbit_span #(.COORD_BITS(COORD_BITS)) u_span (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_valid),
    .in_ready_o  (p_ready),
    .flags_i     (p_flags),
    .a_x_i       (p_a_x),
    .a_y_i       (p_a_y),
    .a_xe_i      (p_a_xe),
    .a_ye_i      (p_a_ye),
    .b_x_i       (p_b_x),
    .b_y_i       (p_b_y),
    .b_xe_i      (p_b_xe),
    .b_ye_i      (p_b_ye),
    .r_i         (p_r),
    .out_valid_o (s_valid),
    .out_ready_i (s_ready),
    .flags_o     (s_flags),
    .dx_o        (s_dx),
    .dy_o        (s_dy),
    .r_o         (s_r)
  );

  hbit_square #(.COORD_BITS(COORD_BITS)) u_square (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_valid),
    .in_ready_o  (s_ready),
    .flags_i     (s_flags),
    .dx_i        (s_dx),
    .dy_i        (s_dy),
    .r_i         (s_r),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .flags_o     (q_flags),
    .dx_sq_o     (q_dx_sq),
    .dy_sq_o     (q_dy_sq),
    .r_sq_o      (q_r_sq)
  );

  hbit_compare #(.COORD_BITS(COORD_BITS)) u_compare (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_ready_o (q_ready),
    .flags_i    (q_flags),
    .dx_sq_i    (q_dx_sq),
    .dy_sq_i    (q_dy_sq),
    .r_sq_i     (q_r_sq),
    .hit_o      (hit_o)
  );

`ifndef ASSERT_OFF
  a_full_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !box_i.ready |-> p_valid && s_valid && q_valid && hit_o.valid && !hit_o.ready)
    else $error("input held off while the pipeline has room");
`endif

endmodule

`default_nettype wire
